// ===== sv/mcd_pkg.sv =====
// Shared types, constants and helper functions for the maze carving engine.
// Depends on nothing; every other file imports it.
package mcd_pkg;

   // Grid and field sizes
   localparam int MAX_ROWS  = 32;
   localparam int MAX_COLS  = 32;
   localparam int RAND_BITS = 16;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int CELL_W    = ROW_W + COL_W;
   localparam int CELLS     = MAX_ROWS * MAX_COLS;
   localparam int DEPTH_W   = CELL_W + 1;
   localparam int DIM_W     = 6;
   localparam int EC_W      = 5;
   localparam int RND_W     = 16;
   localparam int QIDX_W    = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 6;

   // Operation codes
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_CARVE = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRANCE = 2'd2;

   // Neighbor directions, in scan order
   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   // Wall codes on the result channel
   localparam logic WALL_ROW = 1'b0;
   localparam logic WALL_COL = 1'b1;

   // One cell of a row word
   typedef struct packed {
      logic visited;
      logic col_wall;
      logic row_wall;
   } cell_type;

   typedef cell_type [MAX_COLS-1:0] row_word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic latch_run;
      logic clear_wr;
      logic clear_mark;
      logic rd_up;
      logic rd_mid;
      logic rd_dn;
      logic cap_up;
      logic cap_mid;
      logic cap_dn;
      logic pop_rd;
      logic pop_ld;
      logic carve;
      logic wr_dn;
      logic q_rd;
      logic q_set;
      logic refuse;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      op_type op;
      logic   run_ok;
      logic   any_open;
      logic   depth_zero;
      logic   clear_last;
      logic   carve_down;
   } stat_type;

   // Saturate a grid dimension to 2..hi
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v < DIM_W'(2)) r = DIM_W'(2);
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   // Residue mod 3: bit i weighs 2^i mod 3, i.e. 1 or 2; fold three times
   function automatic logic [1:0] mod3(input logic [RAND_BITS-1:0] v);
      logic [5:0] s1;
      logic [3:0] s2;
      logic [2:0] s3;
      logic [2:0] t;
      s1 = '0;
      for (int i = 0; i < RAND_BITS; i++) begin
         s1 = s1 + ((i % 2 == 1) ? {4'd0, v[i], 1'b0} : {5'd0, v[i]});
      end
      s2 = {3'd0, s1[0]} + {2'd0, s1[1], 1'b0} + {3'd0, s1[2]} +
           {2'd0, s1[3], 1'b0} + {3'd0, s1[4]} + {2'd0, s1[5], 1'b0};
      s3 = {2'd0, s2[0]} + {1'b0, s2[1], 1'b0} + {2'd0, s2[2]} + {1'b0, s2[3], 1'b0};
      t  = (s3 >= 3'd3) ? s3 - 3'd3 : s3;
      t  = (t >= 3'd3) ? t - 3'd3 : t;
      return t[1:0];
   endfunction

endpackage

// ===== sv/mcd_datapath.sv =====
// Datapath of the maze carving engine: row memory, path stack, run registers,
// configuration registers and result registers. Depends on mcd_pkg.
module mcd_datapath import mcd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   input  logic [1:0]                req_operation,
   input  logic [RND_W-1:0]          req_random_value,
   input  logic signed [QIDX_W-1:0]  req_query_row,
   input  logic signed [QIDX_W-1:0]  req_query_col,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DAT_W-1:0]      csr_data,
   output logic                      rsp_status,
   output logic [ROW_W-1:0]          rsp_carved_row,
   output logic [COL_W-1:0]          rsp_carved_col,
   output logic                      rsp_opened_wall,
   output logic                      rsp_maze_done,
   output logic                      rsp_row_wall_closed,
   output logic                      rsp_col_wall_closed
);

   // Memories: one word per grid row, and the path stack
   row_word_type          row_mem [MAX_ROWS];
   logic [CELL_W-1:0]     stack_mem [CELLS];

   // Configuration
   logic [DIM_W-1:0]   cfg_rows_ff, cfg_cols_ff;
   logic [EC_W-1:0]    cfg_ec_ff;

   // Run state
   logic [DIM_W-1:0]   run_rows_ff, run_cols_ff;
   logic [COL_W-1:0]   run_ec_ff;
   logic [DEPTH_W-1:0] run_cells_ff;
   logic [ROW_W-1:0]   cur_row_ff;
   logic [COL_W-1:0]   cur_col_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] visited_total_ff;
   logic               run_active_ff;
   logic [ROW_W-1:0]   clear_row_ff;

   // Item registers
   op_type                    op_ff;
   logic [RND_W-1:0]          rnd_ff;
   logic [QIDX_W-1:0]         qrow_ff, qcol_ff;

   // Row words and memory read data
   row_word_type       up_ff, mid_ff, dn_ff, mem_q_ff;
   logic [CELL_W-1:0]  stack_q_ff;

   // Pending result
   logic               res_status_ff;
   logic [ROW_W-1:0]   res_row_ff;
   logic [COL_W-1:0]   res_col_ff;
   logic               res_wall_ff;
   logic               res_rw_ff, res_cw_ff;

   // Start clamping
   logic [DIM_W-1:0]   new_rows, new_cols;
   logic [COL_W-1:0]   new_ec;

   always_comb begin
      new_rows = clamp_dim(cfg_rows_ff, DIM_W'(MAX_ROWS));
      new_cols = clamp_dim(cfg_cols_ff, DIM_W'(MAX_COLS));
      new_ec   = (DIM_W'(cfg_ec_ff) >= new_cols) ? COL_W'(new_cols - DIM_W'(1))
                                                 : COL_W'(cfg_ec_ff);
   end

   // Neighbor scan over the three captured rows
   logic [3:0]         avail;
   logic [2:0]         n_open;
   logic [1:0]         pick_k;
   dir_type            dir;
   logic [COL_W-1:0]   col_lf, col_rt;
   logic [2:0]         seen;

   always_comb begin
      col_lf   = cur_col_ff - COL_W'(1);
      col_rt   = cur_col_ff + COL_W'(1);
      avail[0] = (cur_row_ff != '0) && !up_ff[cur_col_ff].visited;
      avail[1] = ((DIM_W'(cur_row_ff) + DIM_W'(1)) < run_rows_ff) &&
                 !dn_ff[cur_col_ff].visited;
      avail[2] = (cur_col_ff != '0) && !mid_ff[col_lf].visited;
      avail[3] = ((DIM_W'(cur_col_ff) + DIM_W'(1)) < run_cols_ff) &&
                 !mid_ff[col_rt].visited;
      n_open   = 3'($countones(avail));
      unique case (n_open)
         3'd2:    pick_k = {1'b0, rnd_ff[0]};
         3'd3:    pick_k = mod3(rnd_ff[RAND_BITS-1:0]);
         3'd4:    pick_k = rnd_ff[1:0];
         default: pick_k = 2'd0;
      endcase
      dir  = DIR_UP;
      seen = '0;
      for (int i = 0; i < 4; i++) begin
         if (avail[i]) begin
            if (seen == {1'b0, pick_k}) dir = dir_type'(i);
            seen = seen + 3'd1;
         end
      end
   end

   // Carve: modified word, its row and the new cell
   row_word_type       carve_word;
   logic [ROW_W-1:0]   carve_addr, own_row, new_row;
   logic [COL_W-1:0]   own_col, new_col;
   logic               own_wall;

   always_comb begin
      carve_word = mid_ff;
      carve_addr = cur_row_ff;
      own_row    = cur_row_ff;
      own_col    = cur_col_ff;
      own_wall   = WALL_ROW;
      new_row    = cur_row_ff;
      new_col    = cur_col_ff;
      unique case (dir)
         DIR_UP: begin
            carve_word = up_ff;
            carve_word[cur_col_ff].row_wall = 1'b0;
            carve_word[cur_col_ff].visited  = 1'b1;
            carve_addr = cur_row_ff - ROW_W'(1);
            own_row    = cur_row_ff - ROW_W'(1);
            new_row    = cur_row_ff - ROW_W'(1);
         end
         DIR_DOWN: begin
            carve_word[cur_col_ff].row_wall = 1'b0;
            new_row = cur_row_ff + ROW_W'(1);
         end
         DIR_LEFT: begin
            carve_word[col_lf].col_wall = 1'b0;
            carve_word[col_lf].visited  = 1'b1;
            own_col  = col_lf;
            own_wall = WALL_COL;
            new_col  = col_lf;
         end
         DIR_RIGHT: begin
            carve_word[cur_col_ff].col_wall = 1'b0;
            carve_word[col_rt].visited      = 1'b1;
            own_wall = WALL_COL;
            new_col  = col_rt;
         end
         default: ;
      endcase
   end

   // Memory port selection
   logic               rd_en, wr_en;
   logic [ROW_W-1:0]   rd_addr, wr_addr;
   row_word_type       wr_data, clear_word, dn_word;

   always_comb begin
      clear_word = '0;
      for (int c = 0; c < MAX_COLS; c++) begin
         clear_word[c].row_wall = 1'b1;
         clear_word[c].col_wall = 1'b1;
      end
      if (cmd.clear_mark && clear_row_ff == '0) clear_word[run_ec_ff].visited = 1'b1;
      dn_word = dn_ff;
      dn_word[cur_col_ff].visited = 1'b1;

      rd_en = cmd.rd_up || cmd.rd_mid || cmd.rd_dn || cmd.q_rd;
      priority if (cmd.rd_up)  rd_addr = cur_row_ff - ROW_W'(1);
      else if (cmd.rd_mid)     rd_addr = cur_row_ff;
      else if (cmd.rd_dn)      rd_addr = cur_row_ff + ROW_W'(1);
      else                     rd_addr = qrow_ff[ROW_W-1:0];

      wr_en = cmd.clear_wr || cmd.carve || cmd.wr_dn;
      priority if (cmd.clear_wr) begin
         wr_addr = clear_row_ff;
         wr_data = clear_word;
      end else if (cmd.carve) begin
         wr_addr = carve_addr;
         wr_data = carve_word;
      end else begin
         wr_addr = cur_row_ff;
         wr_data = dn_word;
      end
   end

   // Row memory and stack memory
   always_ff @(posedge clock) begin
      if (wr_en) row_mem[wr_addr] <= wr_data;
      if (rd_en) mem_q_ff <= row_mem[rd_addr];
      if (cmd.carve) stack_mem[depth_ff[CELL_W-1:0]] <= {cur_row_ff, cur_col_ff};
      if (cmd.pop_rd) stack_q_ff <= stack_mem[CELL_W'(depth_ff - DEPTH_W'(1))];
   end

   // Row word capture and item registers
   always_ff @(posedge clock) begin
      if (cmd.cap_up)  up_ff  <= mem_q_ff;
      if (cmd.cap_mid) mid_ff <= mem_q_ff;
      if (cmd.cap_dn)  dn_ff  <= mem_q_ff;
      if (cmd.accept) begin
         rnd_ff  <= req_random_value;
         qrow_ff <= req_query_row;
         qcol_ff <= req_query_col;
      end
   end

   // Query decode
   logic q_in_range;
   always_comb begin
      q_in_range = !qrow_ff[QIDX_W-1] && !qcol_ff[QIDX_W-1] &&
                   (qrow_ff[DIM_W-1:0] < run_rows_ff) &&
                   (qcol_ff[DIM_W-1:0] < run_cols_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_rows_ff      <= DIM_W'(8);
         cfg_cols_ff      <= DIM_W'(8);
         cfg_ec_ff        <= '0;
         run_rows_ff      <= DIM_W'(8);
         run_cols_ff      <= DIM_W'(8);
         run_ec_ff        <= '0;
         run_cells_ff     <= DEPTH_W'(64);
         cur_row_ff       <= '0;
         cur_col_ff       <= '0;
         depth_ff         <= '0;
         visited_total_ff <= '0;
         run_active_ff    <= 1'b0;
         clear_row_ff     <= '0;
         op_ff            <= OP_START;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_ROWS:     cfg_rows_ff <= csr_data;
               CSR_COLS:     cfg_cols_ff <= csr_data;
               CSR_ENTRANCE: cfg_ec_ff   <= csr_data[EC_W-1:0];
               default: ;
            endcase
         end
         if (cmd.accept) op_ff <= op_type'(req_operation);
         if (cmd.latch_run) begin
            run_rows_ff      <= new_rows;
            run_cols_ff      <= new_cols;
            run_ec_ff        <= new_ec;
            run_cells_ff     <= DEPTH_W'(new_rows * new_cols);
            cur_row_ff       <= '0;
            cur_col_ff       <= new_ec;
            depth_ff         <= '0;
            visited_total_ff <= DEPTH_W'(1);
            run_active_ff    <= 1'b1;
            clear_row_ff     <= '0;
         end
         if (cmd.clear_wr) clear_row_ff <= clear_row_ff + ROW_W'(1);
         if (cmd.refuse) run_active_ff <= 1'b0;
         if (cmd.pop_rd) depth_ff <= depth_ff - DEPTH_W'(1);
         if (cmd.pop_ld) begin
            cur_row_ff <= stack_q_ff[CELL_W-1:COL_W];
            cur_col_ff <= stack_q_ff[COL_W-1:0];
         end
         if (cmd.carve) begin
            cur_row_ff       <= new_row;
            cur_col_ff       <= new_col;
            depth_ff         <= depth_ff + DEPTH_W'(1);
            visited_total_ff <= visited_total_ff + DEPTH_W'(1);
         end
      end
   end

   // Pending result
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_status_ff <= 1'b0;
         res_row_ff    <= '0;
         res_col_ff    <= '0;
         res_wall_ff   <= 1'b0;
         res_rw_ff     <= 1'b0;
         res_cw_ff     <= 1'b0;
      end
      if (cmd.refuse) res_status_ff <= 1'b1;
      if (cmd.carve) begin
         res_row_ff  <= own_row;
         res_col_ff  <= own_col;
         res_wall_ff <= own_wall;
      end
      if (cmd.q_set) begin
         res_rw_ff <= q_in_range ? mem_q_ff[qcol_ff[COL_W-1:0]].row_wall : 1'b1;
         res_cw_ff <= q_in_range ? mem_q_ff[qcol_ff[COL_W-1:0]].col_wall : 1'b1;
      end
   end

   // Output registers
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status          <= res_status_ff;
         rsp_carved_row      <= res_row_ff;
         rsp_carved_col      <= res_col_ff;
         rsp_opened_wall     <= res_wall_ff;
         rsp_maze_done       <= (visited_total_ff == run_cells_ff);
         rsp_row_wall_closed <= res_rw_ff;
         rsp_col_wall_closed <= res_cw_ff;
      end
   end

   // Status; carve_down is valid while the carve command is up
   always_comb begin
      stat.op         = op_ff;
      stat.run_ok     = run_active_ff && (visited_total_ff != run_cells_ff);
      stat.any_open   = (n_open != 3'd0);
      stat.depth_zero = (depth_ff == '0);
      stat.clear_last = (clear_row_ff == ROW_W'(MAX_ROWS - 1));
      stat.carve_down = (dir == DIR_DOWN);
   end

endmodule

// ===== sv/mcd_ctrl.sv =====
// Controller state machine of the maze carving engine; drives the datapath
// commands and the channel handshakes. Depends on mcd_pkg.
module mcd_ctrl import mcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [16:0] {
      S_WIPE   = 17'h00001,
      S_IDLE   = 17'h00002,
      S_START  = 17'h00004,
      S_CLEAR  = 17'h00008,
      S_CHECK  = 17'h00010,
      S_RD_UP  = 17'h00020,
      S_RD_MID = 17'h00040,
      S_RD_DN  = 17'h00080,
      S_EVAL   = 17'h00100,
      S_PICK   = 17'h00200,
      S_POP    = 17'h00400,
      S_POP_LD = 17'h00800,
      S_CARVE  = 17'h01000,
      S_WR_DN  = 17'h02000,
      S_Q_RD   = 17'h04000,
      S_Q_WAIT = 17'h08000,
      S_FINISH = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_WIPE: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            // op register now holds the accepted code
            unique case (stat.op)
               OP_START: begin
                  cmd.latch_run = 1'b1;
                  state_in      = S_CLEAR;
               end
               OP_CARVE: state_in = S_CHECK;
               OP_QUERY: state_in = S_Q_RD;
               default:  state_in = S_FINISH;
            endcase
         end
         S_CLEAR: begin
            cmd.clear_wr   = 1'b1;
            cmd.clear_mark = 1'b1;
            if (stat.clear_last) state_in = S_FINISH;
         end
         S_CHECK: begin
            if (stat.run_ok) begin
               state_in = S_RD_UP;
            end else begin
               cmd.refuse = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_RD_UP: begin
            cmd.rd_up = 1'b1;
            state_in  = S_RD_MID;
         end
         S_RD_MID: begin
            cmd.cap_up = 1'b1;
            cmd.rd_mid = 1'b1;
            state_in   = S_RD_DN;
         end
         S_RD_DN: begin
            cmd.cap_mid = 1'b1;
            cmd.rd_dn   = 1'b1;
            state_in    = S_EVAL;
         end
         S_EVAL: begin
            cmd.cap_dn = 1'b1;
            state_in   = S_PICK;
         end
         S_PICK: begin
            priority if (stat.any_open) begin
               state_in = S_CARVE;
            end else if (stat.depth_zero) begin
               cmd.refuse = 1'b1;
               state_in   = S_FINISH;
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            cmd.pop_rd = 1'b1;
            state_in   = S_POP_LD;
         end
         S_POP_LD: begin
            cmd.pop_ld = 1'b1;
            state_in   = S_RD_UP;
         end
         S_CARVE: begin
            // a downward carve also marks the new cell in the next row word
            cmd.carve = 1'b1;
            state_in  = stat.carve_down ? S_WR_DN : S_FINISH;
         end
         S_WR_DN: begin
            cmd.wr_dn = 1'b1;
            state_in  = S_FINISH;
         end
         S_Q_RD: begin
            cmd.q_rd = 1'b1;
            state_in = S_Q_WAIT;
         end
         S_Q_WAIT: begin
            cmd.q_set = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result is only loaded into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> slot_free) else $error("result loaded over a pending one");
   // Backtracking never pops an empty stack
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_rd |-> !stat.depth_zero) else $error("pop of empty path stack");
   // An accepted item leaves idle on the next edge
   a_accept_leaves: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == S_START) else $error("item accepted but not started");

endmodule

// ===== sv/maze_carving_dfs_engine.sv =====
// Maze carving engine top level: controller plus datapath. Depends on mcd_pkg.
// A start clears all 32 rows of the row memory; a query reads one row word; a carve
// reads the rows above, at and below the current cell, and when no neighbor is open
// pops the path stack and scans again. One item at a time (req_ready is high only in
// idle); each scan reads the row memory three times through its one read port.
// Reset (synchronous, active high) runs a wipe of all 32 rows of the row memory;
// req_ready stays low until it ends. Configuration writes are always taken, but not in reset.
module maze_carving_dfs_engine import mcd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_operation,
   input  logic [RND_W-1:0]          req_random_value,
   input  logic signed [QIDX_W-1:0]  req_query_row,
   input  logic signed [QIDX_W-1:0]  req_query_col,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_status,
   output logic [ROW_W-1:0]          rsp_carved_row,
   output logic [COL_W-1:0]          rsp_carved_col,
   output logic                      rsp_opened_wall,
   output logic                      rsp_maze_done,
   output logic                      rsp_row_wall_closed,
   output logic                      rsp_col_wall_closed,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DAT_W-1:0]      csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   mcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mcd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_operation),
      .req_random_value    (req_random_value),
      .req_query_row       (req_query_row),
      .req_query_col       (req_query_col),
      .csr_write           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_status          (rsp_status),
      .rsp_carved_row      (rsp_carved_row),
      .rsp_carved_col      (rsp_carved_col),
      .rsp_opened_wall     (rsp_opened_wall),
      .rsp_maze_done       (rsp_maze_done),
      .rsp_row_wall_closed (rsp_row_wall_closed),
      .rsp_col_wall_closed (rsp_col_wall_closed)
   );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the maze carving engine: directed table then random items,
// all results compared against a behavioral maze predictor. Depends on mcd_pkg and the RTL.
module tb_top;
   import mcd_pkg::*;

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   logic [1:0] req_operation;
   logic [RND_W-1:0] req_random_value;
   logic signed [QIDX_W-1:0] req_query_row, req_query_col;
   logic rsp_valid, rsp_ready;
   logic rsp_status, rsp_opened_wall, rsp_maze_done;
   logic [ROW_W-1:0] rsp_carved_row;
   logic [COL_W-1:0] rsp_carved_col;
   logic rsp_row_wall_closed, rsp_col_wall_closed;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   maze_carving_dfs_engine uut (.*);

   typedef struct packed {
      logic status;
      logic [4:0] crow;
      logic [4:0] ccol;
      logic wall;
      logic done;
      logic rwc;
      logic cwc;
   } answer_type;

   typedef struct {
      op_type op;
      logic [15:0] rnd;
      logic signed [6:0] qr;
      logic signed [6:0] qc;
      bit typed;
      answer_type ans;
   } row_type;

   // maze state mirror
   logic [1:0] walls[CELLS];
   bit seen[CELLS];
   int trail[CELLS];
   int depth, cur_r, cur_c, seen_cnt, live;
   int cfg_rows, cfg_cols, cfg_ent, run_r, run_c;

   answer_type pending[$];
   int errors, mismatches;

   function automatic int clampd(int v);
      return v < 2 ? 2 : (v > 32 ? 32 : v);
   endfunction

   function automatic bit maze_full();
      return seen_cnt == run_r * run_c;
   endfunction

   // walk the maze one item forward and return the expected answer
   function automatic answer_type carve_predict(op_type op, logic [15:0] rnd,
                                                logic signed [6:0] qr,
                                                logic signed [6:0] qc);
      answer_type a;
      int nr[4], nc[4];
      int n, k, r2, c2, orow, ocol, w, ec;
      a = '0;
      n = 0;
      if (op == OP_START) begin
         run_r = clampd(cfg_rows);
         run_c = clampd(cfg_cols);
         ec = cfg_ent >= run_c ? run_c - 1 : cfg_ent;
         foreach (walls[i]) begin
            walls[i] = 2'b11;
            seen[i] = 0;
         end
         depth = 0; cur_r = 0; cur_c = ec;
         seen[ec] = 1; seen_cnt = 1; live = 1;
      end else if (op == OP_CARVE) begin
         if (!live || maze_full()) begin
            live = 0; a.status = 1;
         end else begin
            forever begin
               n = 0;
               if (cur_r > 0 && !seen[(cur_r-1)*32+cur_c]) begin
                  nr[n] = cur_r-1; nc[n] = cur_c; n++;
               end
               if (cur_r+1 < run_r && !seen[(cur_r+1)*32+cur_c]) begin
                  nr[n] = cur_r+1; nc[n] = cur_c; n++;
               end
               if (cur_c > 0 && !seen[cur_r*32+cur_c-1]) begin
                  nr[n] = cur_r; nc[n] = cur_c-1; n++;
               end
               if (cur_c+1 < run_c && !seen[cur_r*32+cur_c+1]) begin
                  nr[n] = cur_r; nc[n] = cur_c+1; n++;
               end
               if (n > 0 || depth == 0) break;
               depth--;
               cur_r = trail[depth] / 32;
               cur_c = trail[depth] % 32;
            end
            if (n == 0) begin
               live = 0; a.status = 1;
            end else begin
               k = rnd % n;
               r2 = nr[k]; c2 = nc[k];
               if (r2 != cur_r) begin
                  w = 0; orow = r2 < cur_r ? r2 : cur_r; ocol = cur_c;
               end else begin
                  w = 1; orow = cur_r; ocol = c2 < cur_c ? c2 : cur_c;
               end
               walls[orow*32+ocol][w] = 1'b0;
               trail[depth] = cur_r*32 + cur_c;
               depth++;
               cur_r = r2; cur_c = c2;
               seen[r2*32+c2] = 1;
               seen_cnt++;
               if (maze_full()) live = 0;
               a.crow = 5'(orow); a.ccol = 5'(ocol); a.wall = 1'(w);
            end
         end
      end else if (op == OP_QUERY) begin
         if (qr < 0 || qc < 0 || qr >= run_r || qc >= run_c) begin
            a.rwc = 1; a.cwc = 1;
         end else begin
            a.rwc = walls[int'(qr)*32+int'(qc)][0];
            a.cwc = walls[int'(qr)*32+int'(qc)][1];
         end
      end
      a.done = maze_full();
      return a;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #40000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // valid stays up after the accepting edge only while the next item follows at once
   task automatic send_item(row_type t);
      answer_type a;
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 0;
         idle_cycles(gap);
      end
      req_valid <= 1;
      req_operation <= t.op;
      req_random_value <= t.rnd;
      req_query_row <= t.qr;
      req_query_col <= t.qc;
      do @(posedge clock); while (!req_ready);
      a = carve_predict(t.op, t.rnd, t.qr, t.qc);
      if (t.typed && a != t.ans) begin
         errors++;
         $display("table row disagrees: op %0d expected %h predicted %h", t.op, t.ans, a);
      end
      pending = {pending, a};
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int val);
      req_valid <= 0;
      while (pending.size() != 0) @(posedge clock);
      idle_cycles(40);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val[5:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_ROWS) cfg_rows = val & 63;
      else if (idx == CSR_COLS) cfg_cols = val & 63;
      else cfg_ent = val & 31;
   endtask

   function automatic row_type mk(op_type op, int rnd = 0, int qr = 0, int qc = 0);
      row_type t;
      t.op = op; t.rnd = 16'(rnd); t.qr = 7'(qr); t.qc = 7'(qc);
      t.typed = 0; t.ans = '0;
      return t;
   endfunction

   function automatic row_type mk_typed(op_type op, answer_type a, int qr = 0, int qc = 0);
      row_type t;
      t = mk(op, 0, qr, qc);
      t.typed = 1; t.ans = a;
      return t;
   endfunction

   // random valid query, out-of-range corners mixed in
   function automatic row_type rand_query();
      int qr, qc;
      qr = $urandom_range(0, 9) == 0 ? ($urandom_range(0,1) ? -1 : $urandom_range(run_r, 63))
                                     : $urandom_range(0, run_r-1);
      qc = $urandom_range(0, 9) == 0 ? ($urandom_range(0,1) ? -64 : $urandom_range(run_c, 63))
                                     : $urandom_range(0, run_c-1);
      return mk(OP_QUERY, $urandom(), qr, qc);
   endfunction

   // response side: rsp_ready drops for a random hold after each item taken
   initial begin
      answer_type got, want;
      int hold;
      rsp_ready = 0;
      hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_carved_row, rsp_carved_col, rsp_opened_wall,
                   rsp_maze_done, rsp_row_wall_closed, rsp_col_wall_closed};
            if (pending.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected item %h", got);
            end else begin
               want = pending.pop_front();
               if (got != want) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("item mismatch: expected %h actual %h", want, got);
               end
            end
            hold = $urandom_range(0, 3);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_ready <= (hold == 0);
      end
   end

   initial begin
      row_type plan[$];
      int cfgs[4][3];
      answer_type a;
      int n;
      errors = 0; mismatches = 0;
      reset = 1; req_valid = 0; req_operation = OP_START; req_random_value = 0;
      req_query_row = 0; req_query_col = 0; csr_valid = 0; csr_index = CSR_ROWS; csr_data = 0;
      cfg_rows = 8; cfg_cols = 8; cfg_ent = 0; run_r = 8; run_c = 8;
      depth = 0; cur_r = 0; cur_c = 0; seen_cnt = 0; live = 0;
      foreach (walls[i]) begin
         walls[i] = 2'b11; seen[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: refused carve before start, closed walls, extremes of fields
      a = '0; a.status = 1;
      plan = {plan, mk_typed(OP_CARVE, a)};
      a = '0; a.rwc = 1; a.cwc = 1;
      plan = {plan, mk_typed(OP_QUERY, a, 0, 0)};
      plan = {plan, mk_typed(OP_QUERY, a, -1, 3)};
      plan = {plan, mk_typed(OP_QUERY, a, 63, -64)};
      plan = {plan, mk_typed(OP_NONE, '0)};
      plan = {plan, mk(OP_START)};
      plan = {plan, mk(OP_CARVE, 16'hFFFF)};
      plan = {plan, mk(OP_CARVE, 0)};
      plan = {plan, mk(OP_CARVE, 16'hAAAA)};
      plan = {plan, mk(OP_CARVE, 16'h5555)};
      plan = {plan, mk(OP_QUERY, 0, 0, 0)};
      plan = {plan, mk(OP_QUERY, 0, 7, 7)};
      plan = {plan, mk(OP_QUERY, 0, 8, 0)};
      plan = {plan, mk(OP_NONE, 16'hFFFF, -1, -1)};
      foreach (plan[i]) send_item(plan[i]);

      // 2x2 grid carried to completion, then refused
      write_reg(CSR_ROWS, 0);
      write_reg(CSR_COLS, 1);
      write_reg(CSR_ENTRANCE, 31);
      send_item(mk(OP_START));
      repeat (4) send_item(mk(OP_CARVE, $urandom()));
      send_item(mk(OP_QUERY, 0, 1, 1));

      // random phases over several sizes, extremes included
      cfgs = '{'{32, 32, 31}, '{63, 3, 2}, '{5, 40, 17}, '{3, 4, 1}};
      n = 0;
      for (int p = 0; p < 8; p++) begin
         if (p < 4) begin
            write_reg(CSR_ROWS, cfgs[p][0]);
            write_reg(CSR_COLS, cfgs[p][1]);
            write_reg(CSR_ENTRANCE, cfgs[p][2]);
         end else begin
            write_reg(CSR_ROWS, $urandom_range(0, 12));
            write_reg(CSR_COLS, $urandom_range(0, 12));
            write_reg(CSR_ENTRANCE, $urandom_range(0, 31));
         end
         send_item(mk(OP_START));
         // register change mid-run must not matter until next start
         if (p == 2) write_reg(CSR_ROWS, 2);
         repeat (p == 0 ? 80 : 45) begin
            case ($urandom_range(0, 9))
               0, 1: send_item(rand_query());
               2: if ($urandom_range(0, 3) == 0) send_item(mk(OP_NONE, $urandom(),
                        $urandom(), $urandom()));
               default: send_item(mk(OP_CARVE, $urandom()));
            endcase
         end
      end
      req_valid <= 0;

      // drain, then allow the block to settle
      while (pending.size() != 0) @(posedge clock);
      idle_cycles(50);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ===== maze_carving_dfs_engine.f =====
sv/mcd_pkg.sv
sv/mcd_datapath.sv
sv/mcd_ctrl.sv
sv/maze_carving_dfs_engine.sv
test/tb_top.sv
